@@ rtl/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and constants of the serial audio command link
// Frame bytes, command codes, register indexes and the frame checksum.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

  localparam int unsigned QueueDepth = 12;

  // frame layout: 7E FF 06 cmd 01 dh dl sh sl EF
  localparam int unsigned FrameLen = 10;
  localparam logic [7:0] FrameStart   = 8'h7E;
  localparam logic [7:0] FrameEnd     = 8'hEF;
  localparam logic [7:0] FrameVersion = 8'hFF;
  localparam logic [7:0] FrameLength  = 8'h06;
  localparam logic [7:0] FrameFeedback = 8'h01;

  // received command codes
  localparam logic [7:0] CmdInitDone = 8'h3F;
  localparam logic [7:0] CmdOnline   = 8'h90;
  localparam logic [7:0] CmdAck      = 8'h41;

  // status values that mean the module is up
  localparam logic [7:0] StatusUpA = 8'h02;
  localparam logic [7:0] StatusUpB = 8'h03;

  // config register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgRetryInterval = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxTries      = 1'b1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] RetryIntervalRst = 16'd100;
  localparam logic [3:0]  MaxTriesRst      = 4'd3;

  typedef enum logic [1:0] {
    OpEnqueue = 2'd0,
    OpRxByte  = 2'd1,
    OpTick    = 2'd2
  } opcode_e;

  // decoded receive window
  typedef struct packed {
    logic       ok;
    logic [7:0] cmd;
    logic [7:0] status;
  } rx_frame_t;

  // one step's result, handed to the transmit side
  typedef struct packed {
    logic        send;
    logic [7:0]  cmd;
    logic [15:0] data;
    logic        ready;
    logic [3:0]  pending;
    logic        drop;
    logic        ack;
    logic        gave;
  } tx_desc_t;

  // 16-bit negated sum of the six payload bytes
  function automatic logic [15:0] neg_sum6(input logic [7:0] b1, input logic [7:0] b2,
                                           input logic [7:0] b3, input logic [7:0] b4,
                                           input logic [7:0] b5, input logic [7:0] b6);
    logic [15:0] s;
    s = 16'(b1) + 16'(b2) + 16'(b3) + 16'(b4) + 16'(b5) + 16'(b6);
    return 16'd0 - s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sacl_queue_mem.sv @@
// ----------------------------------------------------------------------------
// sacl_queue_mem: command queue storage
// One write port, one registered read port with write-through.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_queue_mem #(
  parameter int unsigned Depth = sacl_pkg::QueueDepth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [23:0]      wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic [23:0]           rdata_o
);

  logic [23:0] mem_q [Depth];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port follows the next head address; a write to it passes through
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/sacl_rx_window.sv @@
// ----------------------------------------------------------------------------
// sacl_rx_window: receive byte window and frame check
// Ten-byte shift window; reports a valid frame ending in the incoming byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_rx_window (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         shift_i,
  input  wire logic [7:0]   byte_i,
  output sacl_pkg::rx_frame_t frame_o
);

  localparam int unsigned Len = sacl_pkg::FrameLen;

  logic [7:0] win_q [Len];
  logic [7:0] win_d [Len];
  logic [15:0] want_sum;

  // window as it looks with the incoming byte shifted in
  always_comb begin
    for (int k = 0; k < Len - 1; k++) begin
      win_d[k] = win_q[k+1];
    end
    win_d[Len-1] = byte_i;
  end

  assign want_sum = sacl_pkg::neg_sum6(win_d[1], win_d[2], win_d[3],
                                       win_d[4], win_d[5], win_d[6]);

  assign frame_o.ok = (win_d[0] == sacl_pkg::FrameStart) &&
                      (win_d[Len-1] == sacl_pkg::FrameEnd) &&
                      (want_sum == {win_d[7], win_d[8]});
  assign frame_o.cmd    = win_d[3];
  assign frame_o.status = win_d[6];

  // a matched frame is consumed so its bytes are not reused
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Len; k++) begin
        win_q[k] <= 8'h00;
      end
    end else if (shift_i) begin
      for (int k = 0; k < Len; k++) begin
        win_q[k] <= frame_o.ok ? 8'h00 : win_d[k];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/sacl_frame_tx.sv @@
// ----------------------------------------------------------------------------
// sacl_frame_tx: result serializer
// Holds one step's result and streams it: ten frame bytes or one status word.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_frame_tx (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire sacl_pkg::tx_desc_t desc_i,
  output logic                    can_load_o,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // tdata: tx_byte[7:0], device_ready[8], pending_count[12:9],
  //        enqueue_dropped[13], ack_taken[14], gave_up[15]
  output logic [15:0]             m_axis_tdata,
  output logic                    m_axis_tlast,
  // tuser: out_kind[0]
  output logic                    m_axis_tuser
);

  localparam int unsigned IdxW = $clog2(sacl_pkg::FrameLen);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(sacl_pkg::FrameLen - 1);

  logic               busy_q;
  logic [IdxW-1:0]    idx_q;
  sacl_pkg::tx_desc_t desc_q;
  logic [15:0]        csum_q;
  logic               xfer;
  logic               last;
  logic [7:0]         tx_byte;

  assign last       = !desc_q.send || (idx_q == LastIdx);
  assign xfer       = busy_q && m_axis_tready;
  assign can_load_o = !busy_q || (xfer && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (xfer) begin
      busy_q <= !last;
      idx_q  <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      desc_q <= desc_i;
      csum_q <= sacl_pkg::neg_sum6(sacl_pkg::FrameVersion, sacl_pkg::FrameLength,
                                   desc_i.cmd, sacl_pkg::FrameFeedback,
                                   desc_i.data[15:8], desc_i.data[7:0]);
    end
  end

  always_comb begin
    case (idx_q)
      IdxW'(0): tx_byte = sacl_pkg::FrameStart;
      IdxW'(1): tx_byte = sacl_pkg::FrameVersion;
      IdxW'(2): tx_byte = sacl_pkg::FrameLength;
      IdxW'(3): tx_byte = desc_q.cmd;
      IdxW'(4): tx_byte = sacl_pkg::FrameFeedback;
      IdxW'(5): tx_byte = desc_q.data[15:8];
      IdxW'(6): tx_byte = desc_q.data[7:0];
      IdxW'(7): tx_byte = csum_q[15:8];
      IdxW'(8): tx_byte = csum_q[7:0];
      default:  tx_byte = sacl_pkg::FrameEnd;
    endcase
    if (!desc_q.send) begin
      tx_byte = 8'h00;
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tlast  = last;
  assign m_axis_tuser  = desc_q.send;
  assign m_axis_tdata  = {desc_q.gave, desc_q.ack, desc_q.drop, desc_q.pending,
                          desc_q.ready, tx_byte};

endmodule

`default_nettype wire

@@ rtl/serial_audio_cmd_link.sv @@
// ----------------------------------------------------------------------------
// serial_audio_cmd_link: command link to a serial audio module
// Command queue with retry and give-up, frame builder and receive parser.
// ----------------------------------------------------------------------------
// Each input transfer is one step: enqueue a command, feed one received
// byte, or one time tick. A new step is taken every cycle while the result
// side keeps up; a step is held in the input register and then in the
// serializer before its results appear. A tick that sends the head command
// produces ten results, one frame byte per cycle from the serializer while
// the result side takes them; while the frame is sent, one further step
// waits in the input register. Every other step produces one status result. Status fields
// (ready flag, queue level, drop/ack/give-up events) repeat on every result
// of a step. Config writes take effect at the next edge and are meant to be
// done while the link is idle. Queue entries are written before they are
// read, so the queue store needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_audio_cmd_link #(
  parameter int unsigned QUEUE_DEPTH = sacl_pkg::QueueDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: command_code[7:0], command_data[23:8], rx_byte[31:24]
  input  wire logic [31:0]                   s_axis_tdata,
  // tuser: opcode[1:0]
  input  wire logic [1:0]                    s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: tx_byte[7:0], device_ready[8], pending_count[12:9],
  //        enqueue_dropped[13], ack_taken[14], gave_up[15]
  output logic [15:0]                        m_axis_tdata,
  output logic                               m_axis_tlast,
  // tuser: out_kind[0]
  output logic                               m_axis_tuser,
  // config writes
  input  wire logic                          cfg_we_i,
  input  wire logic [sacl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sacl_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned PtrW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned PendW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [PendW-1:0] PendFull = PendW'(QUEUE_DEPTH);

  // config registers
  logic [15:0] retry_interval_q;
  logic [3:0]  max_tries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_interval_q <= sacl_pkg::RetryIntervalRst;
      max_tries_q      <= sacl_pkg::MaxTriesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sacl_pkg::CfgRetryInterval: retry_interval_q <= cfg_wdata_i[15:0];
        sacl_pkg::CfgMaxTries:      max_tries_q      <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // input register
  logic              in_valid_q;
  logic [1:0]        in_op_q;
  logic [7:0]        in_code_q;
  logic [15:0]       in_data_q;
  logic [7:0]        in_rx_q;
  logic              fire;
  logic              can_load;

  assign fire          = in_valid_q && can_load;
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tuser;
      in_code_q <= s_axis_tdata[7:0];
      in_data_q <= s_axis_tdata[23:8];
      in_rx_q   <= s_axis_tdata[31:24];
    end
  end

  // link state
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PendW-1:0] pending_q, pending_d;
  logic [3:0]       tries_q, tries_d;
  logic [15:0]      countdown_q, countdown_d;
  logic             ready_q, ready_d;

  logic             q_we;
  logic [23:0]      head;
  logic             rx_shift;
  sacl_pkg::rx_frame_t rx_frame;
  sacl_pkg::tx_desc_t  desc;
  logic [3:0]       tries_inc;

  assign tries_inc = tries_q + 4'd1;

  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    pending_d   = pending_q;
    tries_d     = tries_q;
    countdown_d = countdown_q;
    ready_d     = ready_q;
    q_we        = 1'b0;
    rx_shift    = 1'b0;
    desc.send   = 1'b0;
    desc.drop   = 1'b0;
    desc.ack    = 1'b0;
    desc.gave   = 1'b0;
    if (fire) begin
      unique case (sacl_pkg::opcode_e'(in_op_q))
        sacl_pkg::OpEnqueue: begin
          if (pending_q < PendFull) begin
            q_we      = 1'b1;
            wr_ptr_d  = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
            pending_d = pending_q + PendW'(1);
          end else begin
            desc.drop = 1'b1;
          end
        end
        sacl_pkg::OpRxByte: begin
          rx_shift = 1'b1;
          if (rx_frame.ok) begin
            if ((rx_frame.cmd == sacl_pkg::CmdOnline) ||
                (rx_frame.cmd == sacl_pkg::CmdInitDone)) begin
              if ((rx_frame.status == sacl_pkg::StatusUpA) ||
                  (rx_frame.status == sacl_pkg::StatusUpB)) begin
                ready_d = 1'b1;
              end
            end else if ((rx_frame.cmd == sacl_pkg::CmdAck) && (pending_q != '0)) begin
              rd_ptr_d    = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
              pending_d   = pending_q - PendW'(1);
              tries_d     = 4'd0;
              countdown_d = 16'd0;
              desc.ack    = 1'b1;
            end
          end
        end
        sacl_pkg::OpTick: begin
          if (countdown_q != 16'd0) begin
            countdown_d = countdown_q - 16'd1;
          end else if (pending_q != '0) begin
            desc.send   = 1'b1;
            countdown_d = retry_interval_q;
            tries_d     = tries_inc;
            // abandon the head once it has been sent max_tries times
            if (tries_inc >= max_tries_q) begin
              tries_d   = 4'd0;
              rd_ptr_d  = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
              pending_d = pending_q - PendW'(1);
              desc.gave = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    desc.cmd     = head[23:16];
    desc.data    = head[15:0];
    desc.ready   = ready_d;
    desc.pending = 4'(pending_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      pending_q   <= '0;
      tries_q     <= 4'd0;
      countdown_q <= 16'd0;
      ready_q     <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      pending_q   <= pending_d;
      tries_q     <= tries_d;
      countdown_q <= countdown_d;
      ready_q     <= ready_d;
    end
  end

  // head entry is read at the next read pointer, so it is current here
  sacl_queue_mem #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (wr_ptr_q),
    .wdata_i ({in_code_q, in_data_q}),
    .raddr_i (rd_ptr_d),
    .rdata_o (head)
  );

  sacl_rx_window u_rx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (rx_shift),
    .byte_i  (in_rx_q),
    .frame_o (rx_frame)
  );

  sacl_frame_tx u_tx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (fire),
    .desc_i        (desc),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

@@ rtl/sacl_checker.sv @@
// ----------------------------------------------------------------------------
// sacl_checker: port-level checks of the command link
// Result stream consistency; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("stalled result changed");

  // status results stand alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("status result without last");

  // a frame closes with the end byte and is not cut short
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && m_axis_tlast |->
      m_axis_tdata[7:0] == sacl_pkg::FrameEnd)
    else $error("frame does not end with end byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser)
    else $error("frame interrupted");

  // one event per step at most
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $countones(m_axis_tdata[15:13]) <= 1)
    else $error("conflicting step events");

endmodule

bind serial_audio_cmd_link sacl_checker u_checker (.*);

`default_nettype wire
